// ===== rtl/kcg_pkg.sv =====
// Package for the k-combination generator.
// Holds the fixed sizes, status and register codes, and the structs passed
// between the sequencer, the slot file and the step unit. No dependencies.
package kcg_pkg;

  localparam int K_MAX  = 16;
  localparam int N_MAX  = 64;
  localparam int SLOT_W = 7;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int N_W    = 7;
  localparam int K_W    = 5;

  localparam logic [1:0] ST_ELEM  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic REG_SET_SIZE     = 1'b0;
  localparam logic REG_CHOOSE_COUNT = 1'b1;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [SLOT_W-1:0] data;
  } slot_wr_t;

  typedef struct packed {
    logic [SLOT_W-1:0] incr;
    logic              below;
  } step_res_t;

endpackage

// ===== rtl/kcg_req_if.sv =====
// Request channel of the k-combination generator.
// Carries the restart flag with valid and ready. No dependencies.
interface kcg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== rtl/kcg_res_if.sv =====
// Result channel of the k-combination generator.
// Carries element, position, last and status with valid and ready.
interface kcg_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] element;
  logic [3:0] position;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output element, output position, output last,
                  output status, input ready);
  modport sink (input valid, input element, input position, input last,
                input status, output ready);
endinterface

// ===== rtl/kcg_cfg_if.sv =====
// Configuration write channel of the k-combination generator.
// Carries a register index and write data with valid and ready.
interface kcg_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/k_combination_generator.sv =====
// Lexicographic k-combination generator, top level.
// Sequencer around the slot file and the shared step unit.
//
// Usage: set_size (register 0) and choose_count (register 1) are written
// over the cfg channel while the block is idle. Each transfer on the req
// channel produces one combination: k transfers on the res channel, one per
// element with its position, and last set on the final one. A request with
// restart set first reloads the start pattern into all 16 slots. Finished,
// empty and invalid settings each give a single result with last set.
// After a request the sequencer scans the slots from the right, refills
// from the advanced slot to the end and then outputs the elements in
// order. All of it runs through the one step unit and the one read port
// of the slot file. req.ready is high only while the sequencer is idle; a
// waiting last result does not hold it off. A stalled receiver freezes the
// output register and holds the sequencer in its emit or response state.
// Synchronous reset clears the slots, the started flag, both registers and
// the output.
module k_combination_generator (
  input logic       clk,
  input logic       rst,
  kcg_req_if.sink   req,
  kcg_res_if.source res,
  kcg_cfg_if.sink   cfg
);
  import kcg_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_SCAN = 6'b000100,
    S_FILL = 6'b001000,
    S_EMIT = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] prev;
  logic              started;
  logic [1:0]        resp_status;
  logic [N_W-1:0]    set_size;
  logic [K_W-1:0]    choose_count;

  logic              out_valid;
  logic [5:0]        out_element;
  logic [3:0]        out_position;
  logic              out_last;
  logic [1:0]        out_status;

  slot_wr_t          wr;
  logic [SLOT_W-1:0] rd_data;
  logic [SLOT_W-1:0] operand;
  step_res_t         step;
  logic [N_W-1:0]    diff;
  logic              bad;
  logic              out_free;
  logic              load_out;
  logic              k_zero;
  logic [SLOT_W-1:0] init_val;
  logic [CNT_W-1:0]  cnt_inc;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign res.valid    = out_valid;
  assign res.element  = out_element;
  assign res.position = out_position;
  assign res.last     = out_last;
  assign res.status   = out_status;

  assign out_free = !out_valid || res.ready;
  assign load_out = out_free && ((state == S_EMIT) || (state == S_RESP));
  assign k_zero   = (choose_count == '0);
  assign diff     = set_size - {{(N_W-K_W){1'b0}}, choose_count};
  assign bad      = ({{(N_W-K_W){1'b0}}, choose_count} > set_size)
                    || (choose_count > K_W'(K_MAX))
                    || (set_size > N_W'(N_MAX));
  assign cnt_inc  = cnt + CNT_W'(1);
  assign operand  = (state == S_FILL) ? prev : rd_data;

  always_comb begin
    if (!k_zero && cnt_inc < choose_count) begin
      init_val = SLOT_W'(cnt);
    end else if (!k_zero && cnt_inc == choose_count) begin
      init_val = {{(SLOT_W-K_W){1'b0}}, choose_count} - SLOT_W'(2);
    end else begin
      init_val = '0;
    end
  end

  always_comb begin
    wr.we   = 1'b0;
    wr.addr = cnt[IDX_W-1:0];
    wr.data = step.incr;
    case (state)
      S_INIT: begin
        wr.we   = 1'b1;
        wr.data = init_val;
      end
      S_SCAN: wr.we = !k_zero && step.below;
      S_FILL: wr.we = (cnt != choose_count);
      default: wr.we = 1'b0;
    endcase
  end

  kcg_slot_file u_slots (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  kcg_step_unit u_step (
    .operand (operand),
    .offset  (cnt[IDX_W-1:0]),
    .diff    (diff),
    .res     (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size     <= '0;
      choose_count <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SET_SIZE:     set_size     <= cfg.data;
        REG_CHOOSE_COUNT: choose_count <= cfg.data[K_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      prev         <= '0;
      started      <= 1'b0;
      resp_status  <= ST_DONE;
      out_element  <= '0;
      out_position <= '0;
      out_last     <= 1'b0;
      out_status   <= ST_ELEM;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (bad) begin
              resp_status <= ST_BAD;
              state       <= S_RESP;
            end else if (req.restart) begin
              started <= 1'b0;
              cnt     <= '0;
              state   <= S_INIT;
            end else begin
              cnt   <= choose_count - K_W'(1);
              state <= S_SCAN;
            end
          end
        end
        S_INIT: begin
          if (cnt == CNT_W'(K_MAX - 1)) begin
            cnt   <= choose_count - K_W'(1);
            state <= S_SCAN;
          end else begin
            cnt <= cnt_inc;
          end
        end
        S_SCAN: begin
          if (!k_zero && step.below) begin
            prev    <= step.incr;
            cnt     <= cnt_inc;
            started <= 1'b1;
            state   <= S_FILL;
          end else if (k_zero || cnt == '0) begin
            if (started) begin
              resp_status <= ST_DONE;
              state       <= S_RESP;
            end else if (k_zero) begin
              started     <= 1'b1;
              resp_status <= ST_EMPTY;
              state       <= S_RESP;
            end else begin
              started <= 1'b1;
              cnt     <= '0;
              state   <= S_EMIT;
            end
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_FILL: begin
          if (cnt == choose_count) begin
            cnt   <= '0;
            state <= S_EMIT;
          end else begin
            prev <= step.incr;
            cnt  <= cnt_inc;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_element  <= rd_data[5:0];
            out_position <= cnt[IDX_W-1:0];
            out_last     <= (cnt_inc == choose_count);
            out_status   <= ST_ELEM;
            if (cnt_inc == choose_count) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt_inc;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_element  <= '0;
            out_position <= '0;
            out_last     <= 1'b1;
            out_status   <= resp_status;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/kcg_slot_file.sv =====
// Slot store holding the current combination, one register per slot.
// One write port and one read port; depends on kcg_pkg.
module kcg_slot_file (
  input  logic                            clk,
  input  logic                            rst,
  input  kcg_pkg::slot_wr_t               wr,
  input  logic [kcg_pkg::IDX_W-1:0]       rd_addr,
  output logic [kcg_pkg::SLOT_W-1:0]      rd_data
);
  import kcg_pkg::*;

  logic [SLOT_W-1:0] slots [K_MAX];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < K_MAX; i++) begin
        slots[i] <= '0;
      end
    end else if (wr.we) begin
      slots[wr.addr] <= wr.data;
    end
  end

  assign rd_data = slots[rd_addr];

endmodule

// ===== rtl/kcg_step_unit.sv =====
// Shared step unit: increments a slot value and compares it to its limit.
// Used by both the scan and the refill phases; depends on kcg_pkg.
module kcg_step_unit (
  input  logic [kcg_pkg::SLOT_W-1:0] operand,
  input  logic [kcg_pkg::IDX_W-1:0]  offset,
  input  logic [kcg_pkg::N_W-1:0]    diff,
  output kcg_pkg::step_res_t         res
);
  import kcg_pkg::*;

  logic [N_W:0] bound;

  assign bound     = {{(N_W+1-IDX_W){1'b0}}, offset} + {1'b0, diff};
  assign res.incr  = operand + SLOT_W'(1);
  assign res.below = $signed({operand[SLOT_W-1], operand[SLOT_W-1], operand})
                     < $signed({1'b0, bound});

endmodule

// ===== rtl/kcg_checker.sv =====
// Port-level checker for the k-combination generator, with its bind.
// Depends on kcg_pkg and on the top level's channel ports.
module kcg_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [5:0] res_element,
  input logic [3:0] res_position,
  input logic       res_last,
  input logic [1:0] res_status
);
  import kcg_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_element)
      && $stable(res_position) && $stable(res_last) && $stable(res_status))
    else $error("Stalled result changed before its transfer.");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_ELEM |-> res_last)
    else $error("Status result without last mark.");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_ELEM |-> res_element == '0 && res_position == '0)
    else $error("Status result carries element data.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Request accepted while the previous one is in progress.");

endmodule

bind k_combination_generator kcg_checker u_kcg_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_element  (res.element),
  .res_position (res.position),
  .res_last     (res.last),
  .res_status   (res.status)
);
